>>> rtl/matrix_keypad_scan_debounce_unit_defines.svh
// Assertion macros shared by the keypad scanner checkers
`ifndef MATRIX_KEYPAD_SCAN_DEBOUNCE_UNIT_DEFINES_SVH
`define MATRIX_KEYPAD_SCAN_DEBOUNCE_UNIT_DEFINES_SVH

// Clocked check, switched off while reset is asserted
`define KPSD_ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define KPSD_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/kpsd_pkg.sv
// Types and constants shared by the keypad scanner modules
`timescale 1ns / 1ps

package kpsd_pkg;

	localparam int unsigned ROWS = 4;
	localparam int unsigned COLS = 4;

	localparam logic [63:0] CODE_MAP_LOW_RST  = 64'd2681389126241169969;
	localparam logic [63:0] CODE_MAP_HIGH_RST = 64'd2813935235823646775;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_CODE_MAP_LOW  = 2'd0,
		CFG_CODE_MAP_HIGH = 2'd1
	} cfg_index_t;

	// One classified scan tick, handed from front to back
	typedef struct packed {
		logic [3:0] drive;
		logic [3:0] press;
		logic [1:0] row;
	} tick_t;

endpackage

>>> rtl/kpsd_queue.sv
// Small first-in first-out queue between the front and back parts
`timescale 1ns / 1ps

module kpsd_queue #(
	parameter int unsigned WIDTH = 10,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output logic             not_empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [PW-1:0] LAST_C  = PW'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == DEPTH_C);
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	// Store the incoming item
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_C) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_C) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/kpsd_front.sv
// Front part: takes scan ticks, updates key histories and finds new presses
`timescale 1ns / 1ps

module kpsd_front #(
	parameter int unsigned DEBOUNCE_SAMPLES = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [3:0]    column_lines,
	input  logic          q_full,
	output logic          q_push,
	output kpsd_pkg::tick_t q_data
);

	import kpsd_pkg::*;

	localparam int unsigned N = DEBOUNCE_SAMPLES;

	logic [1:0]   scan_row_q;
	logic [N-1:0] hist_q [ROWS][COLS];
	logic         rel_q  [ROWS][COLS];

	logic [N-1:0] hist_d [COLS];
	logic         rel_d  [COLS];
	logic [3:0]   press;
	logic [1:0]   next_row;
	logic         take;

	assign in_ready = !q_full;
	assign take     = in_valid && !q_full;
	assign next_row = scan_row_q + 2'd1;

	// Shift in the new column samples and classify each key of the row
	always_comb begin
		for (int c = 0; c < COLS; c++) begin
			hist_d[c] = {hist_q[scan_row_q][c][N-2:0], column_lines[c]};
			rel_d[c]  = rel_q[scan_row_q][c];
			press[c]  = 1'b0;
			if (hist_d[c] == '0) begin
				press[c] = rel_q[scan_row_q][c];
				rel_d[c] = 1'b0;
			end else if (hist_d[c] == '1) begin
				rel_d[c] = 1'b1;
			end
		end
	end

	assign q_push     = take;
	assign q_data.row   = scan_row_q;
	assign q_data.press = press;
	assign q_data.drive = ~(4'b0001 << next_row);

	// Commit the row state and advance the row pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_row_q <= '0;
			for (int r = 0; r < ROWS; r++) begin
				for (int c = 0; c < COLS; c++) begin
					hist_q[r][c] <= '1;
					rel_q[r][c]  <= 1'b1;
				end
			end
		end else if (take) begin
			scan_row_q <= next_row;
			for (int c = 0; c < COLS; c++) begin
				hist_q[scan_row_q][c] <= hist_d[c];
				rel_q[scan_row_q][c]  <= rel_d[c];
			end
		end
	end

endmodule

>>> rtl/kpsd_back.sv
// Back part: turns each classified tick into one result per press, or one empty result if it has none
`timescale 1ns / 1ps

module kpsd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_not_empty,
	input  kpsd_pkg::tick_t q_head,
	output logic            q_pop,
	input  logic [63:0]     code_map_low,
	input  logic [63:0]     code_map_high,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [3:0]      row_drive,
	output logic            press_valid,
	output logic [3:0]      key_index,
	output logic [7:0]      key_code,
	output logic            last_result
);

	import kpsd_pkg::*;

	logic       active_q;
	logic [3:0] rem_q;
	logic [3:0] drive_q;
	logic [1:0] row_q;

	logic       out_valid_q;
	logic [3:0] row_drive_q;
	logic       press_valid_q;
	logic [3:0] key_index_q;
	logic [7:0] key_code_q;
	logic       last_result_q;

	logic [3:0]  src_mask;
	logic [3:0]  src_drive;
	logic [1:0]  src_row;
	logic        have;
	logic        advance;
	logic [1:0]  col;
	logic [3:0]  low_bit;
	logic [3:0]  rem_d;
	logic        last;
	logic [3:0]  idx;
	logic [63:0] word;
	logic [7:0]  code;

	// Work from the held tick, or straight from the queue head
	assign src_mask  = active_q ? rem_q   : q_head.press;
	assign src_drive = active_q ? drive_q : q_head.drive;
	assign src_row   = active_q ? row_q   : q_head.row;
	assign have      = active_q || q_not_empty;
	assign advance   = have && (!out_valid_q || out_ready);
	assign q_pop     = advance && !active_q;

	// Pick the lowest remaining press column
	always_comb begin
		col     = 2'd0;
		low_bit = 4'b0000;
		for (int c = 3; c >= 0; c--) begin
			if (src_mask[c]) begin
				col     = 2'(c);
				low_bit = 4'b0001 << c;
			end
		end
	end

	assign rem_d = src_mask & ~low_bit;
	assign last  = (rem_d == 4'b0000);
	assign idx   = {src_row, col};
	assign word  = idx[3] ? code_map_high : code_map_low;
	assign code  = word[{idx[2:0], 3'b000} +: 8];

	// Hold the tick between results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (advance) begin
			active_q <= !last;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rem_q   <= rem_d;
			drive_q <= src_drive;
			row_q   <= src_row;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			row_drive_q   <= src_drive;
			press_valid_q <= (src_mask != 4'b0000);
			key_index_q   <= (src_mask != 4'b0000) ? idx  : 4'd0;
			key_code_q    <= (src_mask != 4'b0000) ? code : 8'd0;
			last_result_q <= last;
		end
	end

	assign out_valid   = out_valid_q;
	assign row_drive   = row_drive_q;
	assign press_valid = press_valid_q;
	assign key_index   = key_index_q;
	assign key_code    = key_code_q;
	assign last_result = last_result_q;

endmodule

>>> rtl/matrix_keypad_scan_debounce_unit.sv
// Top level of the 4x4 keypad scanner with per-key debounce
//
// Input channel: one item per scan tick carries column_lines, the four
// column samples of the row currently driven low (0 = key closed).
// Output channel: one item per new debounced press of that row, in column
// order, with key_index and key_code from the code map; a tick with no new
// press yields a single item with press_valid low. Every item carries the
// row_drive pattern for the next row; last_result marks a tick's final item.
// Configuration: cfg_we writes cfg_data to code_map_low (index 0) or
// code_map_high (index 1); other indexes are ignored. Write only when idle.
// The first result of a tick passes through the queue and then the output register.
// Throughput: the front takes one tick per cycle while its two-entry queue
// has room; the back emits one result per cycle while out_ready allows, so
// a tick yields max(1, presses) results, at most four.
// Reset: row pointer to row 0, all histories to all ones, all keys released,
// code maps to their default values, queue and output emptied.
// Stall: results hold on the output while out_ready is low; the queue then
// fills and in_ready falls.
`timescale 1ns / 1ps

module matrix_keypad_scan_debounce_unit #(
	parameter int unsigned DEBOUNCE_SAMPLES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  column_lines,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  row_drive,
	output logic        press_valid,
	output logic [3:0]  key_index,
	output logic [7:0]  key_code,
	output logic        last_result
);

	import kpsd_pkg::*;

	logic [63:0] code_map_low_q;
	logic [63:0] code_map_high_q;
	logic        q_push;
	logic        q_full;
	logic        q_pop;
	logic        q_not_empty;
	tick_t       q_in;
	tick_t       q_head;

	// Code map registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_map_low_q  <= CODE_MAP_LOW_RST;
			code_map_high_q <= CODE_MAP_HIGH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_CODE_MAP_LOW:  code_map_low_q  <= cfg_data;
				CFG_CODE_MAP_HIGH: code_map_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	kpsd_front #(
		.DEBOUNCE_SAMPLES(DEBOUNCE_SAMPLES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.column_lines (column_lines),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_data       (q_in)
	);

	kpsd_queue #(
		.WIDTH ($bits(tick_t)),
		.DEPTH (2)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.not_empty (q_not_empty)
	);

	kpsd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_not_empty   (q_not_empty),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.code_map_low  (code_map_low_q),
		.code_map_high (code_map_high_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.row_drive     (row_drive),
		.press_valid   (press_valid),
		.key_index     (key_index),
		.key_code      (key_code),
		.last_result   (last_result)
	);

endmodule

>>> rtl/kpsd_checker.sv
// Port-level checks of the keypad scanner, bound to its top level
`timescale 1ns / 1ps
`include "matrix_keypad_scan_debounce_unit_defines.svh"

module kpsd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [3:0] row_drive,
	input logic       press_valid,
	input logic [3:0] key_index,
	input logic [7:0] key_code,
	input logic       last_result
);

	// A stalled result holds
	`KPSD_ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(row_drive) && $stable(key_index) && $stable(key_code) && $stable(press_valid) && $stable(last_result), "stalled result changed")

	// A tick without a press closes with one empty result
	`KPSD_ASSERT_CLK(a_empty_result, out_valid && !press_valid |-> last_result && key_index == 4'd0 && key_code == 8'd0, "malformed empty result")

	// Exactly one row is driven low
	`KPSD_ASSERT_CLK(a_one_row, out_valid |-> $countones(row_drive) == 3, "row drive not one-cold")

	// Nothing is offered during reset
	`KPSD_ASSERT_RST(a_reset_quiet, !arst_n |-> !out_valid, "result during reset")

endmodule

bind matrix_keypad_scan_debounce_unit kpsd_checker u_kpsd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.row_drive   (row_drive),
	.press_valid (press_valid),
	.key_index   (key_index),
	.key_code    (key_code),
	.last_result (last_result)
);
